// ----- hw/rtl/csmv_pkg.sv -----
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types and constants for the compressed-row sparse matrix times
// vector core: action codes, queue entry layout and field widths.
// ----------------------------------------------------------------------------
package csmv_pkg;

  localparam int IDX_W              = 10;
  localparam int VAL_W              = 32;
  localparam int ROWNUM_W           = 16;
  localparam int ACC_W              = 64;
  localparam int FRAC_SHIFT         = 16;
  localparam int VEC_DEPTH_DEF      = 1024;
  localparam int ROW_COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // action code on the input channel
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MAC   = 2'd1,
    ACT_EMPTY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // operation carried from front to back
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
    logic                    col_ok;
  } qent_t;

endpackage

// ----- hw/rtl/csmv_ram.sv -----
// ----------------------------------------------------------------------------
// csmv_ram
// Generic single-port RAM: one write or read address per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/csmv_front.sv -----
// ----------------------------------------------------------------------------
// csmv_front
// Request intake: takes a request, classifies it, drops the ones that do
// nothing and hands the rest to the queue.
// ----------------------------------------------------------------------------
module csmv_front #(
  parameter int VEC_DEPTH = csmv_pkg::VEC_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_action,
  input  logic [csmv_pkg::IDX_W-1:0]          in_index,
  input  logic signed [csmv_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_row_end,
  output logic                                push,
  output csmv_pkg::qent_t                     push_data,
  input  logic                                q_full
);

  import csmv_pkg::*;

  logic        vld_r, vld_nxt;
  qent_t       ent_r, ent_nxt;
  logic        accept;
  logic        keep;
  logic        in_range;
  logic [31:0] idx_ext;
  action_t     act;

  assign busy      = vld_r && q_full;
  assign push      = vld_r && !q_full;
  assign push_data = ent_r;
  assign accept    = start && !busy;

  assign idx_ext  = 32'(in_index);
  assign in_range = idx_ext < 32'(VEC_DEPTH);
  assign act      = action_t'(in_action);

  always_comb begin
    keep            = 1'b0;
    ent_nxt         = ent_r;
    ent_nxt.idx     = in_index;
    ent_nxt.value   = in_value;
    ent_nxt.row_end = in_row_end;
    ent_nxt.col_ok  = in_range;
    ent_nxt.op      = OP_LOAD;
    unique case (act)
      ACT_LOAD: begin
        // loads past the store are dropped here
        keep       = in_range;
        ent_nxt.op = OP_LOAD;
      end
      ACT_MAC: begin
        keep       = 1'b1;
        ent_nxt.op = OP_MAC;
      end
      ACT_EMPTY: begin
        keep       = 1'b1;
        ent_nxt.op = OP_EMPTY;
      end
      ACT_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b0;
    end
    if (accept) begin
      vld_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ----- hw/rtl/csmv_queue.sv -----
// ----------------------------------------------------------------------------
// csmv_queue
// Short request queue between the front and the back, flop based.
// ----------------------------------------------------------------------------
module csmv_queue #(
  parameter int DEPTH = csmv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  csmv_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output csmv_pkg::qent_t head,
  output logic            empty
);

  import csmv_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qent_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/csmv_back.sv -----
// ----------------------------------------------------------------------------
// csmv_back
// Execution pipeline: vector store access, multiply, saturating accumulate,
// round and saturate to Q16.16, result register.
// ----------------------------------------------------------------------------
module csmv_back #(
  parameter int VEC_DEPTH      = csmv_pkg::VEC_DEPTH_DEF,
  parameter int ROW_COUNT_BITS = csmv_pkg::ROW_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  csmv_pkg::qent_t                     head,
  output logic                                pop,
  output logic                                out_valid,
  output logic signed [csmv_pkg::VAL_W-1:0]   out_row_sum,
  output logic [csmv_pkg::ROWNUM_W-1:0]       out_row_number
);

  import csmv_pkg::*;

  localparam int ADDR_W = $clog2(VEC_DEPTH);
  localparam int SH_W   = ACC_W - FRAC_SHIFT;

  // store access
  logic [31:0]              hd_idx_ext;
  logic [ADDR_W-1:0]        ram_addr;
  logic                     ram_we;
  logic [VAL_W-1:0]         ram_rdata;

  // stage 1: read data returns
  logic                     s1_vld_r, s1_vld_nxt;
  op_t                      s1_op_r;
  logic signed [VAL_W-1:0]  s1_value_r;
  logic                     s1_row_end_r;
  logic                     s1_col_ok_r;
  logic signed [VAL_W-1:0]  x_sel;

  // stage 2: product
  logic                     s2_vld_r;
  op_t                      s2_op_r;
  logic                     s2_row_end_r;
  logic signed [ACC_W-1:0]  prod_r, prod_nxt;

  // stage 3: accumulate
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W:0]    acc_wide;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [ROW_COUNT_BITS-1:0] row_cnt_r, row_cnt_nxt;
  logic [31:0]              row_cnt_ext;
  logic                     emit_r, emit_nxt;
  logic signed [ACC_W-1:0]  sum_r, sum_nxt;
  logic [ROWNUM_W-1:0]      rownum_r, rownum_nxt;

  // stage 4: round and saturate
  logic signed [SH_W:0]     q_rnd;
  logic signed [VAL_W-1:0]  q_sat;

  assign pop        = !q_empty;
  assign hd_idx_ext = 32'(head.idx);
  assign ram_addr   = hd_idx_ext[ADDR_W-1:0];
  assign ram_we     = pop && (head.op == OP_LOAD);

  csmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head.value),
    .rdata (ram_rdata)
  );

  assign s1_vld_nxt = pop && (head.op != OP_LOAD);

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r      <= head.op;
      s1_value_r   <= head.value;
      s1_row_end_r <= head.row_end;
      s1_col_ok_r  <= head.col_ok;
    end
  end

  // column beyond the store multiplies by zero
  assign x_sel    = s1_col_ok_r ? $signed(ram_rdata) : '0;
  assign prod_nxt = ACC_W'(s1_value_r) * ACC_W'(x_sel);

  always_ff @(posedge clk) begin
    s2_op_r      <= s1_op_r;
    s2_row_end_r <= s1_row_end_r;
    prod_r       <= prod_nxt;
  end

  // saturating 64-bit add
  assign acc_wide = {acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r};
  always_comb begin
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_sum = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sum = acc_wide[ACC_W-1:0];
    end
  end

  assign row_cnt_ext = 32'(row_cnt_r);

  always_comb begin
    acc_nxt     = acc_r;
    row_cnt_nxt = row_cnt_r;
    emit_nxt    = 1'b0;
    sum_nxt     = '0;
    rownum_nxt  = row_cnt_ext[ROWNUM_W-1:0];
    if (s2_vld_r) begin
      if (s2_op_r == OP_MAC) begin
        acc_nxt = acc_sum;
        if (s2_row_end_r) begin
          emit_nxt    = 1'b1;
          sum_nxt     = acc_sum;
          acc_nxt     = '0;
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end else begin
        // empty row: zero sum, open accumulation carries on
        emit_nxt    = 1'b1;
        row_cnt_nxt = row_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      acc_r     <= '0;
      row_cnt_r <= '0;
      emit_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s1_vld_r;
      acc_r     <= acc_nxt;
      row_cnt_r <= row_cnt_nxt;
      emit_r    <= emit_nxt;
      out_valid <= emit_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    rownum_r <= rownum_nxt;
  end

  // floor shift plus the half bit gives round half up
  assign q_rnd = {sum_r[ACC_W-1], sum_r[ACC_W-1:FRAC_SHIFT]}
               + (SH_W + 1)'(sum_r[FRAC_SHIFT-1]);

  always_comb begin
    if (!q_rnd[SH_W] && (|q_rnd[SH_W-1:VAL_W-1])) begin
      q_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (q_rnd[SH_W] && !(&q_rnd[SH_W-1:VAL_W-1])) begin
      q_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      q_sat = q_rnd[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_row_sum    <= q_sat;
    out_row_number <= rownum_r;
  end

endmodule

// ----- hw/rtl/csr_sparse_matrix_vector_multiply_core.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_core
// Sparse matrix times dense vector in compressed-row order, Q16.16 values.
// ----------------------------------------------------------------------------
// Usage: first load the dense vector with action load (index = address,
// value = entry), then stream the matrix nonzeros with action nonzero
// (index = column, value = element, row_end on the last one of a row) or
// action empty-row for rows without nonzeros. A request is taken at a
// rising edge with start high and busy low.
// Each row end or empty row produces one result: out_valid is high for
// exactly one cycle with out_row_sum (64-bit saturating sum, rounded and
// saturated to Q16.16) and out_row_number. The receiver cannot stall.
// A request passes the front register, the queue, stage 1, stage 2, then emit_r.
// Throughput: one request per cycle sustained; the back end retires one
// queued request every cycle through the single-port vector store, so the
// queue never fills and busy stays low in practice.
// Reset (rst_n low, synchronous) clears the accumulator, the row counter
// and the queue; vector store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_core #(
  parameter int VEC_DEPTH      = csmv_pkg::VEC_DEPTH_DEF,
  parameter int ROW_COUNT_BITS = csmv_pkg::ROW_COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH    = csmv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_action,
  input  logic [csmv_pkg::IDX_W-1:0]          in_index,
  input  logic signed [csmv_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_row_end,
  output logic                                out_valid,
  output logic signed [csmv_pkg::VAL_W-1:0]   out_row_sum,
  output logic [csmv_pkg::ROWNUM_W-1:0]       out_row_number
);

  import csmv_pkg::*;

  logic  push, q_full, pop, q_empty;
  qent_t push_data, head;

  csmv_front #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_row_end (in_row_end),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  csmv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  csmv_back #(
    .VEC_DEPTH      (VEC_DEPTH),
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_row_sum    (out_row_sum),
    .out_row_number (out_row_number)
  );

endmodule

// ----- verif/csr_sparse_matrix_vector_multiply_core_tb.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_core_tb
// Self-checking bench for the compressed-row sparse matrix times vector core.
// Requests go in through the start/busy command port. A bit-exact row-sum
// predictor keeps its own vector store, 64-bit accumulator and row counter,
// and queues one expected row per row end or empty row. Every out_valid
// pulse is checked field by field against the oldest queued row.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_core_tb;
  import csmv_pkg::*;

  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  DRAIN_WAIT  = 12;
  localparam int  PHASE_ITEMS = 200;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [VAL_W-1:0] row_sum;
    logic [ROWNUM_W-1:0]     row_number;
  } row_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [1:0]                  in_action;
  logic [IDX_W-1:0]            in_index;
  logic signed [VAL_W-1:0]     in_value;
  logic                        in_row_end;
  logic                        out_valid;
  logic signed [VAL_W-1:0]     out_row_sum;
  logic [ROWNUM_W-1:0]         out_row_number;

  // predictor state
  logic signed [VAL_W-1:0] vec_model [VEC_DEPTH_DEF];
  bit                      vec_loaded [VEC_DEPTH_DEF];
  int                      loaded_cols [$];
  longint                  row_acc;
  logic [ROWNUM_W-1:0]     row_idx_model;
  row_result_t             pending_rows [$];
  row_result_t             exp_row;

  int  err_count   = 0;
  int  cycle_count = 0;
  int  burst_left  = 0;
  bit  steady      = 1'b0;

  csr_sparse_matrix_vector_multiply_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_row_sum    (out_row_sum),
    .out_row_number (out_row_number)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint acc_add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? ACC_MIN : ACC_MAX;
    return s;
  endfunction

  // q32.32 to q16.16, round half up, clamp to 32 bits
  function automatic logic signed [VAL_W-1:0] q16_round_sat(longint acc);
    longint q;
    q = acc >>> FRAC_SHIFT;
    if (acc[FRAC_SHIFT-1])
      q = q + 1;
    if (q > Q16_MAX)
      return VAL_MAX;
    if (q < Q16_MIN)
      return VAL_MIN;
    return q[VAL_W-1:0];
  endfunction

  function automatic void model_request(action_t act, logic [IDX_W-1:0] idx,
                                        logic signed [VAL_W-1:0] val, logic last);
    row_result_t r;
    case (act)
      ACT_LOAD: begin
        vec_model[idx] = val;
        if (!vec_loaded[idx]) begin
          vec_loaded[idx] = 1'b1;
          loaded_cols.push_back(idx);
        end
      end
      ACT_MAC: begin
        row_acc = acc_add_sat(row_acc, longint'(val) * longint'(vec_model[idx]));
        if (last) begin
          r.row_sum    = q16_round_sat(row_acc);
          r.row_number = row_idx_model;
          pending_rows.push_back(r);
          row_idx_model = row_idx_model + 1'b1;
          row_acc       = 0;
        end
      end
      ACT_EMPTY: begin
        // open row sum is kept and carries into the next row
        r.row_sum    = '0;
        r.row_number = row_idx_model;
        pending_rows.push_back(r);
        row_idx_model = row_idx_model + 1'b1;
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row_sum %0d row_number %0d",
                 $time, out_row_sum, out_row_number);
        err_count++;
      end else begin
        exp_row = pending_rows.pop_front();
        if (out_row_sum !== exp_row.row_sum) begin
          $display("%0t: row_sum mismatch, expected %0d, actual %0d",
                   $time, exp_row.row_sum, out_row_sum);
          err_count++;
        end
        if (out_row_number !== exp_row.row_number) begin
          $display("%0t: row_number mismatch, expected %0d, actual %0d",
                   $time, exp_row.row_number, out_row_number);
          err_count++;
        end
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one request, held until the core takes it
  task automatic issue_request(action_t act, logic [IDX_W-1:0] idx,
                               logic signed [VAL_W-1:0] val, logic last);
    if (!steady) begin
      if (burst_left == 0) begin
        hold_off($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    start      <= 1'b1;
    in_action  <= act;
    in_index   <= idx;
    in_value   <= val;
    in_row_end <= last;
    do @(posedge clk); while (busy !== 1'b0);
    model_request(act, idx, val, last);
  endtask

  // pause the sender until every queued row has come out
  task automatic drain_results();
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_q16();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2, 3:    v = $urandom;
      default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] pick_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  // accumulator clamps at both ends, output clamps, rounding ties both signs
  task automatic test_saturation_and_rounding();
    issue_request(ACT_LOAD, 10'd0, VAL_MIN, 1'b1);
    issue_request(ACT_LOAD, 10'd1023, VAL_MAX, 1'b0);
    issue_request(ACT_LOAD, 10'd1, 32'sd1, 1'b1);
    issue_request(ACT_LOAD, 10'd2, 32'sd0, 1'b0);
    repeat (2) issue_request(ACT_MAC, 10'd0, VAL_MIN, 1'b0);
    issue_request(ACT_MAC, 10'd0, VAL_MIN, 1'b1);
    repeat (2) issue_request(ACT_MAC, 10'd0, VAL_MAX, 1'b0);
    issue_request(ACT_MAC, 10'd0, VAL_MAX, 1'b1);
    issue_request(ACT_MAC, 10'd1, 32'sh0000_8000, 1'b1);
    issue_request(ACT_MAC, 10'd1, -32'sh0000_8000, 1'b1);
    issue_request(ACT_MAC, 10'd1023, VAL_MAX, 1'b1);
    drain_results();
  endtask

  // empty row inside an open row, unused action code, load with row end set
  task automatic test_empty_rows_and_noise();
    issue_request(ACT_EMPTY, 10'd0, 32'sd0, 1'b0);
    issue_request(ACT_MAC, 10'd1, 32'sh0001_8000, 1'b0);
    issue_request(ACT_NONE, 10'h3FF, VAL_MIN, 1'b1);
    issue_request(ACT_EMPTY, 10'h3FF, VAL_MAX, 1'b1);
    issue_request(ACT_MAC, 10'd2, VAL_MAX, 1'b1);
    issue_request(ACT_LOAD, 10'd2, 32'sh0002_0000, 1'b1);
    issue_request(ACT_MAC, 10'd2, 32'sh0001_0000, 1'b1);
    drain_results();
  endtask

  // run of empty rows with random don't-care fields
  task automatic test_empty_row_run();
    int n;
    n = $urandom_range(8, 24);
    for (int i = 0; i < n; i++)
      issue_request(ACT_EMPTY, IDX_W'($urandom), rand_q16(), 1'($urandom));
    drain_results();
  endtask

  // well-formed rows with random content, plus empty rows, reloads and noise
  task automatic test_random_rows();
    int items;
    int len;
    for (int phase = 0; phase < 3; phase++) begin
      items  = 0;
      steady = (phase == 1);
      for (int i = 0; i < 40; i++) begin
        issue_request(ACT_LOAD, IDX_W'($urandom), rand_q16(), 1'($urandom));
        items++;
      end
      while (items < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            issue_request(ACT_EMPTY, IDX_W'($urandom), rand_q16(), 1'($urandom));
            items++;
          end
          2:
            issue_request(ACT_NONE, IDX_W'($urandom), rand_q16(), 1'($urandom));
          3: begin
            issue_request(ACT_LOAD, IDX_W'($urandom), rand_q16(), 1'($urandom));
            items++;
          end
          4: begin
            // row left open, it runs on into whatever follows
            issue_request(ACT_MAC, pick_col(), rand_q16(), 1'b0);
            items++;
          end
          default: begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
              issue_request(ACT_MAC, pick_col(), rand_q16(), k == len - 1);
            items += len;
          end
        endcase
      end
      drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_action  <= ACT_LOAD;
    in_index   <= '0;
    in_value   <= '0;
    in_row_end <= 1'b0;
    row_acc       = 0;
    row_idx_model = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_saturation_and_rounding();
    test_empty_rows_and_noise();
    test_empty_row_run();
    test_random_rows();

    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
